// ===== hdl/sorted_store_search_assert.svh =====
// Assertion macros for the sorted store search block.
`ifndef SORTED_STORE_SEARCH_ASSERT_SVH
`define SORTED_STORE_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define SSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_store_search: assertion failed");
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_store_search: assertion failed");
`else
`define SSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/sss_pkg.sv =====
package sss_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int REP_W       = 8;
    localparam int CMP_W       = (CNT_W > REP_W) ? CNT_W : REP_W;
    localparam int TOT_W       = 8;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

endpackage

// ===== hdl/sorted_store_search.sv =====
// Sorted store search: a store of up to STORE_DEPTH signed 32-bit values held in one
// single-port-read synchronous RAM. One beat in gives one beat out. An append makes
// one RAM write per copy. A search halves its window per probe; each probe sets the RAM
// read address in S_SRCH_RD and compares the registered read data in S_SRCH_CMP. If
// anything was appended since the last search and the store holds more than one value,
// an insertion sort runs first: per element the key is read, each larger element is
// shifted up one place, and the key is written into the gap. The next beat is taken
// once the current one is finished; its result waits in an output register, so a
// stalled result does not block the next input beat.
`include "sorted_store_search_assert.svh"

module sorted_store_search (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_value,
    input  logic [7:0]         s_repeat_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [7:0]         m_element_total,
    output logic               m_overflowed
);
    import sss_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_APPEND     = 9'b000000010,
        S_SORT_KEY   = 9'b000000100,
        S_SORT_KEYW  = 9'b000001000,
        S_SORT_SHIFT = 9'b000010000,
        S_SORT_PLACE = 9'b000100000,
        S_SRCH_RD    = 9'b001000000,
        S_SRCH_CMP   = 9'b010000000,
        S_FINISH     = 9'b100000000
    } state_t;

    logic signed [31:0] store_mem [STORE_DEPTH];
    logic signed [31:0] rdata_reg;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               sorted_reg, sorted_next;
    logic               m_valid_reg, m_valid_next;

    logic signed [31:0] value_reg, value_next;
    logic signed [31:0] key_reg, key_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic               found_reg, found_next;
    logic               over_reg, over_next;
    logic               m_found_reg, m_found_next;
    logic [TOT_W-1:0]   m_total_reg, m_total_next;
    logic               m_over_reg, m_over_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  waddr;
    logic signed [31:0] wdata;
    logic [ADDR_W-1:0]  raddr;

    logic [CNT_W-1:0]   room;
    logic [CMP_W-1:0]   reps_x;
    logic [CMP_W-1:0]   room_x;
    logic [CNT_W-1:0]   mid;
    logic               sort_last;

    assign room      = CNT_W'(STORE_DEPTH) - count_reg;
    assign reps_x    = CMP_W'(s_repeat_count);
    assign room_x    = CMP_W'(room);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sort_last = (CNT_W'(i_reg) + CNT_W'(1)) >= count_reg;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_element_total = m_total_reg;
    assign m_overflowed    = m_over_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        sorted_next  = sorted_reg;
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        key_next     = key_reg;
        rem_next     = rem_reg;
        i_next       = i_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        found_next   = found_reg;
        over_next    = over_reg;
        m_found_next = m_found_reg;
        m_total_next = m_total_reg;
        m_over_next  = m_over_reg;
        mem_we       = 1'b0;
        waddr        = pos_reg;
        wdata        = key_reg;
        raddr        = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    value_next = s_value;
                    found_next = 1'b0;
                    over_next  = 1'b0;
                    case (req_t'(s_req_type))
                        REQ_CLEAR: begin
                            count_next  = '0;
                            sorted_next = 1'b1;
                            state_next  = S_FINISH;
                        end
                        REQ_APPEND: begin
                            rem_next   = (reps_x > room_x) ? room : CNT_W'(s_repeat_count);
                            over_next  = (reps_x > room_x);
                            state_next = S_APPEND;
                        end
                        REQ_SEARCH: begin
                            if (!sorted_reg && count_reg > CNT_W'(1)) begin
                                i_next     = ADDR_W'(1);
                                state_next = S_SORT_KEY;
                            end else begin
                                sorted_next = 1'b1;
                                lo_next     = '0;
                                hi_next     = count_reg;
                                state_next  = S_SRCH_RD;
                            end
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                if (rem_reg != '0) begin
                    mem_we      = 1'b1;
                    waddr       = count_reg[ADDR_W-1:0];
                    wdata       = value_reg;
                    count_next  = count_reg + CNT_W'(1);
                    rem_next    = rem_reg - CNT_W'(1);
                    sorted_next = 1'b0;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SORT_KEY: begin
                raddr      = i_reg;
                state_next = S_SORT_KEYW;
            end
            S_SORT_KEYW: begin
                key_next   = rdata_reg;
                pos_next   = i_reg;
                raddr      = i_reg - ADDR_W'(1);
                state_next = S_SORT_SHIFT;
            end
            S_SORT_SHIFT: begin
                mem_we = 1'b1;
                if (rdata_reg > key_reg) begin
                    wdata    = rdata_reg;
                    pos_next = pos_reg - ADDR_W'(1);
                    if (pos_reg == ADDR_W'(1)) begin
                        state_next = S_SORT_PLACE;
                    end else begin
                        raddr = pos_reg - ADDR_W'(2);
                    end
                end else if (sort_last) begin
                    sorted_next = 1'b1;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    state_next  = S_SRCH_RD;
                end else begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = S_SORT_KEY;
                end
            end
            S_SORT_PLACE: begin
                mem_we = 1'b1;
                if (sort_last) begin
                    sorted_next = 1'b1;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    state_next  = S_SRCH_RD;
                end else begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = S_SORT_KEY;
                end
            end
            S_SRCH_RD: begin
                if (lo_reg < hi_reg) begin
                    raddr      = mid[ADDR_W-1:0];
                    mid_next   = mid;
                    state_next = S_SRCH_CMP;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SRCH_CMP: begin
                if (rdata_reg == value_reg) begin
                    found_next = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    if (rdata_reg < value_reg) begin
                        lo_next = mid_reg + CNT_W'(1);
                    end else begin
                        hi_next = mid_reg;
                    end
                    state_next = S_SRCH_RD;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_total_next = TOT_W'(count_reg);
                    m_over_next  = over_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sorted_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sorted_reg  <= sorted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        key_reg     <= key_next;
        rem_reg     <= rem_next;
        i_reg       <= i_next;
        pos_reg     <= pos_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        found_reg   <= found_next;
        over_reg    <= over_next;
        m_found_reg <= m_found_next;
        m_total_reg <= m_total_next;
        m_over_reg  <= m_over_next;
    end

    // count never passes capacity; append writes only below it
    `SSS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(STORE_DEPTH))
    `SSS_ASSERT_IMPL(a_append_room, aclk, aresetn, (state_reg == S_APPEND) && (rem_reg != '0), count_reg < CNT_W'(STORE_DEPTH))
    `SSS_ASSERT_IMPL(a_search_sorted, aclk, aresetn, (state_reg == S_SRCH_RD) || (state_reg == S_SRCH_CMP), sorted_reg)
    `SSS_ASSERT_IMPL(a_search_window, aclk, aresetn, (state_reg == S_SRCH_CMP), (lo_reg <= mid_reg) && (mid_reg < hi_reg) && (hi_reg <= count_reg))

endmodule

// ===== tb/sv/sorted_store_search_tb.sv =====
`timescale 1ns / 1ps

module sorted_store_search_tb;
    import sss_pkg::*;

    localparam int  CLK_HALF     = 4;
    localparam int  RST_CYCLES   = 7;
    localparam int  RANDOM_BEATS = 1150;
    localparam int  DRAIN_CYCLES = 64;
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct packed {
        logic       found;
        logic [7:0] total;
        logic       over;
    } search_res_t;

    typedef struct {
        req_t               req;
        logic signed [31:0] val;
        logic [7:0]         reps;
        bit                 pinned;
        search_res_t        res;
    } dir_row_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type     = REQ_NOP;
    logic signed [31:0] s_value        = '0;
    logic [7:0]         s_repeat_count = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_found;
    logic [7:0]         m_element_total;
    logic               m_overflowed;

    // typed-in expectation travelling with the beat
    bit                 s_pinned       = 1'b0;
    search_res_t        s_pinned_res   = '0;

    int     sender_idle   = 20;
    int     receiver_idle = 88;
    int     errors        = 0;
    int     beats_in      = 0;
    int     results_seen  = 0;
    int     hits          = 0;
    int     overflows     = 0;
    longint cycles        = 0;

    logic signed [31:0] shadow_vals [STORE_DEPTH];
    int                 shadow_cnt    = 0;
    bit                 shadow_sorted = 1'b1;

    search_res_t expected_res [$];
    dir_row_t    directed [$];

    sorted_store_search u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_value         (s_value),
        .s_repeat_count  (s_repeat_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_element_total (m_element_total),
        .m_overflowed    (m_overflowed)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic search_res_t store_apply(req_t req, logic signed [31:0] val,
                                                logic [7:0] reps);
        search_res_t        r;
        int                 i;
        int                 j;
        int                 lo;
        int                 hi;
        int                 mid;
        logic signed [31:0] key;
        r = '0;
        case (req)
            REQ_CLEAR: begin
                shadow_cnt    = 0;
                shadow_sorted = 1'b1;
            end
            REQ_APPEND: begin
                for (i = 0; i < int'(reps); i++) begin
                    if (shadow_cnt >= STORE_DEPTH) begin
                        r.over = 1'b1;
                        break;
                    end
                    shadow_vals[shadow_cnt] = val;
                    shadow_cnt++;
                    shadow_sorted = 1'b0;
                end
            end
            REQ_SEARCH: begin
                if (!shadow_sorted) begin
                    for (i = 1; i < shadow_cnt; i++) begin
                        key = shadow_vals[i];
                        j   = i;
                        while (j > 0 && shadow_vals[j-1] > key) begin
                            shadow_vals[j] = shadow_vals[j-1];
                            j--;
                        end
                        shadow_vals[j] = key;
                    end
                    shadow_sorted = 1'b1;
                end
                lo = 0;
                hi = shadow_cnt;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_vals[mid] == val) begin
                        r.found = 1'b1;
                        break;
                    end
                    if (shadow_vals[mid] < val) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
            end
            default: ;
        endcase
        r.total = shadow_cnt[7:0];
        return r;
    endfunction

    task automatic check_field(string what, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    task automatic add_row(req_t req, logic signed [31:0] val, logic [7:0] reps, bit pinned,
                           logic found, logic [7:0] total, logic over);
        dir_row_t row;
        row.req       = req;
        row.val       = val;
        row.reps      = reps;
        row.pinned    = pinned;
        row.res.found = found;
        row.res.total = total;
        row.res.over  = over;
        directed.push_back(row);
    endtask

    task automatic send_beat(req_t req, logic signed [31:0] val, logic [7:0] reps,
                             bit pinned, search_res_t res);
        while ($urandom_range(0, 99) < sender_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_value        <= val;
        s_repeat_count <= reps;
        s_pinned       <= pinned;
        s_pinned_res   <= res;
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    always @(posedge aclk) begin : monitor
        search_res_t pred;
        search_res_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pred = store_apply(req_t'(s_req_type), s_value, s_repeat_count);
                expected_res.push_back(s_pinned ? s_pinned_res : pred);
                beats_in++;
            end
            if (m_valid && m_ready) begin
                if (expected_res.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual %0b/%0d/%0b",
                             $time, m_found, m_element_total, m_overflowed);
                end else begin
                    want = expected_res.pop_front();
                    check_field("found", want.found, m_found);
                    check_field("element_total", want.total, m_element_total);
                    check_field("overflowed", want.over, m_overflowed);
                    results_seen++;
                    if (m_found) hits++;
                    if (m_overflowed) overflows++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int                 rand_beats;
        int                 n_ops;
        int                 k;
        int                 i;
        logic signed [31:0] pool [4];
        logic signed [31:0] v;
        logic [7:0]         reps;
        req_t               req;

        rand_beats = 0;

        add_row(REQ_SEARCH, 32'sd0,         8'd0,   1'b1, 1'b0, 8'd0,   1'b0);
        add_row(REQ_NOP,    -32'sd1,        8'd255, 1'b1, 1'b0, 8'd0,   1'b0);
        add_row(REQ_APPEND, 32'h7FFF_FFFF,  8'd0,   1'b1, 1'b0, 8'd0,   1'b0);
        add_row(REQ_APPEND, 32'h7FFF_FFFF,  8'd1,   1'b1, 1'b0, 8'd1,   1'b0);
        add_row(REQ_APPEND, 32'h8000_0000,  8'd2,   1'b1, 1'b0, 8'd3,   1'b0);
        add_row(REQ_APPEND, -32'sd1,        8'd3,   1'b1, 1'b0, 8'd6,   1'b0);
        add_row(REQ_APPEND, 32'sd0,         8'd1,   1'b1, 1'b0, 8'd7,   1'b0);
        add_row(REQ_SEARCH, 32'h7FFF_FFFF,  8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_SEARCH, 32'h8000_0000,  8'd9,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_SEARCH, 32'sd5,         8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_SEARCH, -32'sd1,        8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_APPEND, 32'sd2,         8'd1,   1'b1, 1'b0, 8'd8,   1'b0);
        add_row(REQ_SEARCH, 32'sd2,         8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_APPEND, 32'sd42,        8'd255, 1'b1, 1'b0, 8'd128, 1'b1);
        add_row(REQ_APPEND, 32'sd1,         8'd1,   1'b1, 1'b0, 8'd128, 1'b1);
        add_row(REQ_APPEND, 32'sd1,         8'd0,   1'b1, 1'b0, 8'd128, 1'b0);
        add_row(REQ_SEARCH, 32'sd42,        8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_SEARCH, 32'sd1,         8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_NOP,    32'sd42,        8'd7,   1'b1, 1'b0, 8'd128, 1'b0);
        add_row(REQ_CLEAR,  32'sd0,         8'd0,   1'b1, 1'b0, 8'd0,   1'b0);
        add_row(REQ_SEARCH, 32'sd42,        8'd0,   1'b1, 1'b0, 8'd0,   1'b0);
        add_row(REQ_APPEND, 32'sd5,         8'd128, 1'b1, 1'b0, 8'd128, 1'b0);
        add_row(REQ_APPEND, 32'sd7,         8'hAA,  1'b1, 1'b0, 8'd128, 1'b1);
        add_row(REQ_SEARCH, 32'sd5,         8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
        add_row(REQ_CLEAR,  -32'sd1,        8'd255, 1'b1, 1'b0, 8'd0,   1'b0);

        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[r]) begin
            send_beat(directed[r].req, directed[r].val, directed[r].reps,
                      directed[r].pinned, directed[r].res);
        end

        while (rand_beats < RANDOM_BEATS) begin
            if (rand_beats >= 2 * RANDOM_BEATS / 3) begin
                sender_idle   = 0;
                receiver_idle = 0;
            end else if (rand_beats >= RANDOM_BEATS / 3) begin
                sender_idle   = 88;
                receiver_idle = 20;
            end

            if ($urandom_range(0, 99) < 85) begin
                // clear, then appends and searches over a small value pool
                for (i = 0; i < 4; i++) begin
                    case ($urandom_range(0, 3))
                        0: pool[i] = $urandom;
                        1: begin
                            pool[i] = $urandom_range(0, 20);
                            pool[i] = pool[i] - 32'sd10;
                        end
                        2: pool[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        default: pool[i] = $urandom_range(0, 1000);
                    endcase
                end
                send_beat(REQ_CLEAR, $urandom, 8'($urandom), 1'b0, '0);
                rand_beats++;
                n_ops = $urandom_range(3, 12);
                repeat (n_ops) begin
                    if ($urandom_range(0, 99) < 55) begin
                        v    = pool[$urandom_range(0, 3)];
                        reps = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 6));
                        send_beat(REQ_APPEND, v, reps, 1'b0, '0);
                    end else begin
                        k = $urandom_range(0, 99);
                        if (k < 70) begin
                            v = pool[$urandom_range(0, 3)];
                        end else if (k < 85) begin
                            v = pool[$urandom_range(0, 3)];
                            v = $urandom_range(0, 1) ? v + 32'sd1 : v - 32'sd1;
                        end else begin
                            v = $urandom;
                        end
                        send_beat(REQ_SEARCH, v, 8'($urandom), 1'b0, '0);
                    end
                    rand_beats++;
                end
            end else begin
                // noise: any code, any value, mostly short repeats
                repeat ($urandom_range(1, 4)) begin
                    req  = req_t'($urandom_range(0, 3));
                    reps = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 3));
                    send_beat(req, $urandom, reps, 1'b0, '0);
                    if (req != REQ_NOP) rand_beats++;
                end
            end
        end
        s_valid <= 1'b0;

        while (expected_res.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d beats in and %0d results checked over three idling phases,",
                 beats_in, results_seen);
        $display("with %0d search hits and %0d overflowing appends.", hits, overflows);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
